[sv/wheel_encoder_multiturn_tracker_unit_assert.svh]
// ----------------------------------------------------------------------------
// wheel encoder multiturn tracker assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ENCODER_MULTITURN_TRACKER_UNIT_ASSERT_SVH
`define WHEEL_ENCODER_MULTITURN_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// consequent checked in the same cycle as the antecedent
`define MTT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequent checked in the cycle after the antecedent
`define MTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MTT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define MTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/mtt_pkg.sv]
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants of the wheel encoder multiturn tracker.
// ----------------------------------------------------------------------------
package mtt_pkg;

   localparam int ENCODER_BITS_DEF = 14;
   localparam int ENC_IN_W         = 14;
   localparam int TURNS_W          = 17;
   localparam int COUNT_W          = 32;
   localparam int POS_W            = 15;
   localparam int POS_Q_W          = 14;
   // full scale is at most 1000 revolutions of counts
   localparam int FS_EXTRA_W       = 10;
   localparam int DIVC_W           = 7;

   localparam logic [TURNS_W-1:0] TURNS_LIMIT = 17'd100000;
   localparam logic [DIVC_W-1:0]  FS_DIVISOR  = 7'd100;
   localparam int                 FS_ROUND    = 50;
   localparam logic [POS_W-1:0]   MID_POS     = 15'd16383;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 32'sh8000_0000;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_ZERO   = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [ENC_IN_W-1:0] encoder_value;
   } mtt_req_type;

   typedef struct packed {
      logic [POS_W-1:0]          wheel_position;
      logic signed [COUNT_W-1:0] overrun_count;
      logic signed [COUNT_W-1:0] turn_count;
   } mtt_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mtt_div_stat_type;

endpackage

[sv/mtt_sdiv.sv]
// ----------------------------------------------------------------------------
// mtt_sdiv
// Bit-serial restoring divider: one dividend bit shifted in per cycle.
// ----------------------------------------------------------------------------
module mtt_sdiv
   import mtt_pkg::*;
#(
   parameter int REM_W = DIVC_W,
   parameter int STEPS = POS_Q_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [REM_W-1:0] rem_init,
   input  logic [STEPS-1:0] dvd_bits,
   input  logic [REM_W-1:0] divisor,
   output mtt_div_stat_type stat,
   output logic [STEPS-1:0] quotient
);

   localparam int CNT_W = $clog2(STEPS + 1);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [STEPS-1:0] sh_ff, sh_in;
   logic [REM_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, sh_ff[STEPS-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      sh_in   = sh_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         sh_in   = dvd_bits;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so one subtract decides the bit
         rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         sh_in  = {sh_ff[STEPS-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = sh_ff;

endmodule

[sv/mtt_accum.sv]
// ----------------------------------------------------------------------------
// mtt_accum
// Angle unwrap and saturating multi-turn count.
// ----------------------------------------------------------------------------
module mtt_accum
   import mtt_pkg::*;
#(
   parameter int EB = ENCODER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic                      cmd,
   input  logic [EB-1:0]             raw,
   output logic signed [COUNT_W-1:0] count
);

   localparam int D_W = EB + 2;
   localparam logic signed [D_W-1:0] CPR  = D_W'(1) << EB;
   localparam logic signed [D_W-1:0] HALF = D_W'(1) << (EB - 1);

   logic [EB-1:0]             prev_ff, prev_in;
   logic                      primed_ff, primed_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;

   logic signed [D_W-1:0]     diff;
   logic signed [D_W-1:0]     step;
   logic signed [COUNT_W:0]   sum;
   logic signed [COUNT_W-1:0] sat;

   always_comb begin
      diff = $signed({2'b00, raw}) - $signed({2'b00, prev_ff});
      // exactly half a revolution is kept as it is
      if (diff > HALF) begin
         step = diff - CPR;
      end else if (diff < -HALF) begin
         step = diff + CPR;
      end else begin
         step = diff;
      end
      sum = {count_ff[COUNT_W-1], count_ff} + {{(COUNT_W + 1 - D_W){step[D_W-1]}}, step};
      if (sum[COUNT_W] != sum[COUNT_W-1]) begin
         sat = sum[COUNT_W] ? COUNT_MIN : COUNT_MAX;
      end else begin
         sat = sum[COUNT_W-1:0];
      end

      prev_in   = prev_ff;
      primed_in = primed_ff;
      count_in  = count_ff;
      if (take) begin
         if (cmd == CMD_ZERO) begin
            count_in = '0;
         end else if (!primed_ff) begin
            // first sample only primes the angle
            prev_in   = raw;
            primed_in = 1'b1;
            count_in  = '0;
         end else begin
            prev_in  = raw;
            count_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         primed_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         prev_ff   <= prev_in;
         primed_ff <= primed_in;
         count_ff  <= count_in;
      end
   end

   assign count = count_ff;

endmodule

[sv/wheel_encoder_multiturn_tracker_unit.sv]
// ----------------------------------------------------------------------------
// wheel encoder multiturn tracker
// Each request beat (an encoder angle sample or a set-zero command) gives one
// response beat with the scaled wheel position, the overrun past full scale
// and the signed multi-turn count. One beat is worked on at a time; it passes
// the clamp and load states and the 14-step bit-serial position divider on
// its way to the response register. A new request is taken while the
// previous response still waits. A write of the travel limit starts a
// bit-serial divide by 100 that recomputes full scale; requests are held off
// until it is finished.
// ----------------------------------------------------------------------------
`include "wheel_encoder_multiturn_tracker_unit_assert.svh"

module wheel_encoder_multiturn_tracker_unit
   import mtt_pkg::*;
#(
   parameter int ENCODER_BITS = ENCODER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mtt_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mtt_rsp_type        rsp_data,
   input  logic               csr_wr_en,
   input  logic [TURNS_W-1:0] csr_wr_data
);

   localparam int FS_W = ENCODER_BITS + FS_EXTRA_W;
   localparam int TD_W = TURNS_W + ENCODER_BITS;
   localparam int N_W  = FS_W + POS_Q_W;
   localparam logic [FS_W-1:0] FS_RESET = FS_W'(1) << ENCODER_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLAMP = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [FS_W-1:0]           fs_ff;
   logic [FS_W-1:0]           a_ff, a_in;
   logic                      neg_ff, neg_in;
   logic                      zfs_ff, zfs_in;
   logic signed [COUNT_W-1:0] over_ff, over_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mtt_rsp_type               rsp_data_ff;

   logic                      accept;
   logic                      rsp_load;
   logic signed [COUNT_W-1:0] count;

   logic [TURNS_W-1:0]        turns_sat;
   logic [TD_W-1:0]           fs_dvd;
   mtt_div_stat_type          fs_stat;
   logic [TD_W-1:0]           fs_q;

   logic [N_W-1:0]            prod;
   mtt_div_stat_type          pos_stat;
   logic [POS_Q_W-1:0]        pos_q;
   logic [POS_W-1:0]          pos;

   logic signed [COUNT_W:0]   cnt_x;
   logic signed [COUNT_W:0]   fs_x;
   logic signed [COUNT_W:0]   over_hi;
   logic signed [COUNT_W:0]   over_lo;
   logic                      hi;
   logic                      lo;
   logic [COUNT_W-1:0]        mag;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !fs_stat.busy;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   mtt_accum #(
      .EB (ENCODER_BITS)
   ) u_accum (
      .clock (clock),
      .reset (reset),
      .take  (accept),
      .cmd   (req_data.cmd),
      .raw   (ENCODER_BITS'(req_data.encoder_value)),
      .count (count)
   );

   // full scale = (turns * counts per rev + 50) / 100
   always_comb begin
      turns_sat = (csr_wr_data > TURNS_LIMIT) ? TURNS_LIMIT : csr_wr_data;
      fs_dvd    = {turns_sat, {ENCODER_BITS{1'b0}}} + TD_W'(FS_ROUND);
   end

   mtt_sdiv #(
      .REM_W (DIVC_W),
      .STEPS (TD_W)
   ) u_fs_div (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_wr_en),
      .rem_init ('0),
      .dvd_bits (fs_dvd),
      .divisor  (FS_DIVISOR),
      .stat     (fs_stat),
      .quotient (fs_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FS_RESET;
      end else if (fs_stat.done) begin
         fs_ff <= fs_q[FS_W-1:0];
      end
   end

   // clamp to full scale, overrun and magnitude for the divider
   always_comb begin
      cnt_x   = {count[COUNT_W-1], count};
      fs_x    = $signed((COUNT_W + 1)'(fs_ff));
      over_hi = cnt_x - fs_x;
      over_lo = cnt_x + fs_x;
      hi      = cnt_x > fs_x;
      lo      = cnt_x < -fs_x;
      mag     = count[COUNT_W-1] ? (COUNT_W'(0) - count) : count;
      zfs_in  = (fs_ff == '0);
      neg_in  = count[COUNT_W-1];
      if (zfs_in) begin
         over_in = '0;
      end else if (hi) begin
         over_in = over_hi[COUNT_W-1:0];
      end else if (lo) begin
         over_in = over_lo[COUNT_W-1:0];
      end else begin
         over_in = '0;
      end
      a_in = (hi || lo) ? fs_ff : FS_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLAMP) begin
         a_ff    <= a_in;
         neg_ff  <= neg_in;
         zfs_ff  <= zfs_in;
         over_ff <= over_in;
      end
   end

   // a * 16383 as a shift and subtract
   assign prod = {a_ff, {POS_Q_W{1'b0}}} - {{POS_Q_W{1'b0}}, a_ff};

   mtt_sdiv #(
      .REM_W (FS_W),
      .STEPS (POS_Q_W)
   ) u_pos_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_LOAD),
      .rem_init (prod[N_W-1:POS_Q_W]),
      .dvd_bits (prod[POS_Q_W-1:0]),
      .divisor  (fs_ff),
      .stat     (pos_stat),
      .quotient (pos_q)
   );

   always_comb begin
      if (zfs_ff) begin
         pos = MID_POS;
      end else if (neg_ff) begin
         pos = MID_POS - {1'b0, pos_q};
      end else begin
         pos = MID_POS + {1'b0, pos_q};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (pos_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.wheel_position <= pos;
         rsp_data_ff.overrun_count  <= over_ff;
         rsp_data_ff.turn_count     <= count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MTT_ASSERT_SAME(a_pos_div_in_div, clock, reset, pos_stat.busy, state_ff == ST_DIV, "position divider busy outside divide state")
   `MTT_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_valid && rsp_ready && (state_ff != ST_DONE), !rsp_valid, "response beat taken but valid stayed high")
   `MTT_ASSERT_NEXT(a_csr_blocks_req, clock, reset, csr_wr_en && !reset, !req_ready, "request taken while full scale is recomputed")

endmodule
